// File: rtl/tlb_page_table_translator_defines.svh
// assertion macros shared by the translator checks
`ifndef TLB_PAGE_TABLE_TRANSLATOR_DEFINES_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define TLBPT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlbpt check failed");

// next-cycle implication, disabled while in reset
`define TLBPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlbpt check failed");

`endif

// File: rtl/tlbpt_pkg.sv
// shared types and defaults for the tlb / page table translator
`default_nettype none

package tlbpt_pkg;

    localparam int TLBPT_TLB_SLOTS   = 16;
    localparam int TLBPT_PAGE_COUNT  = 256;
    localparam int TLBPT_FRAME_COUNT = 256;
    localparam int TLBPT_OFFSET_BITS = 8;

    localparam int TLBPT_VA_W    = 16;
    localparam int TLBPT_PA_W    = 16;
    localparam int TLBPT_IDX_W   = 8;
    localparam int TLBPT_COUNT_W = 32;

    typedef enum logic [1:0] {
        OUT_TLB_HIT     = 2'd0,
        OUT_PT_HIT      = 2'd1,
        OUT_FAULT_ALLOC = 2'd2,
        OUT_FAULT_NONE  = 2'd3
    } tlbpt_outcome_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } tlbpt_state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } tlbpt_mem_ctl_t;

endpackage

`default_nettype wire

// File: rtl/tlbpt_ptmem.sv
// page table memory: one entry per page, valid bit plus frame, registered read
`default_nettype none

module tlbpt_ptmem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int DATA_W = 9
) (
    input  wire logic                     clk,
    input  wire tlbpt_pkg::tlbpt_mem_ctl_t ctl,
    input  wire logic [ADDR_W-1:0]        rd_addr,
    input  wire logic [ADDR_W-1:0]        wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    output logic      [DATA_W-1:0]        rd_data
);
    import tlbpt_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/tlbpt_tlb.sv
// fully associative tlb with fifo replacement
`default_nettype none

module tlbpt_tlb #(
    parameter int TLB_SLOTS = 16,
    parameter int PAGE_W    = 8,
    parameter int FRAME_W   = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [PAGE_W-1:0]  lookup_page,
    output logic                    hit,
    output logic      [FRAME_W-1:0] hit_frame,
    input  wire logic               ins_en,
    input  wire logic [PAGE_W-1:0]  ins_page,
    input  wire logic [FRAME_W-1:0] ins_frame
);
    import tlbpt_pkg::*;

    localparam int SLOT_W = (TLB_SLOTS > 1) ? $clog2(TLB_SLOTS) : 1;

    logic [TLB_SLOTS-1:0] valid_reg;
    logic [PAGE_W-1:0]    page_reg  [TLB_SLOTS];
    logic [FRAME_W-1:0]   frame_reg [TLB_SLOTS];
    logic [SLOT_W-1:0]    slot_reg;
    logic [SLOT_W-1:0]    slot_next;
    logic [TLB_SLOTS-1:0] match;

    // at most one slot can match, so the frames are simply or-ed together
    always_comb
    begin
        hit_frame = '0;
        for (int i = 0; i < TLB_SLOTS; i++)
        begin
            match[i] = valid_reg[i] && (page_reg[i] == lookup_page);
            if (match[i])
            begin
                hit_frame = hit_frame | frame_reg[i];
            end
        end
        hit = |match;
    end

    assign slot_next = (slot_reg == SLOT_W'(TLB_SLOTS - 1)) ? '0 : slot_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            slot_reg  <= '0;
        end
        else if (ins_en)
        begin
            valid_reg[slot_reg] <= 1'b1;
            slot_reg            <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ins_en)
        begin
            page_reg[slot_reg]  <= ins_page;
            frame_reg[slot_reg] <= ins_frame;
        end
    end

endmodule

`default_nettype wire

// File: rtl/tlb_page_table_translator.sv
// top level: demand-paging translator with tlb, page table memory and frame allocator
//
// usage
//   input channel (in_valid / in_ready) carries one virtual_address word: the bits
//   above OFFSET_BITS are the page (taken modulo PAGE_COUNT), the rest the offset
//   output channel (out_valid / out_ready) carries one result word per input word:
//   physical address, outcome, frame, faulting page and three saturating counters
//   flow: the page table read is launched at the edge that accepts a word; the tlb
//   is compared and the read data used in the lookup state that follows, and the
//   page table write-back, tlb insert and result register all load at the edge
//   that ends the lookup state, once the output register is free to take the word
//   a new word is accepted only in the idle state, so the next word is not taken
//   until the current one has left the lookup state
//   reset: tlb valid bits, counters and the frame allocator clear at once; the
//   page table is then swept one entry a cycle over all PAGE_COUNT entries (256 by
//   default), with in_ready low until the sweep ends
//   stall: one finished result waits in the output register while the next word is
//   accepted and looked up; that word then holds in the lookup cycle until the
//   output register is taken
//   once FRAME_COUNT frames are handed out, further faults report no free frame
`default_nettype none

module tlb_page_table_translator #(
    parameter int TLB_SLOTS   = tlbpt_pkg::TLBPT_TLB_SLOTS,
    parameter int PAGE_COUNT  = tlbpt_pkg::TLBPT_PAGE_COUNT,
    parameter int FRAME_COUNT = tlbpt_pkg::TLBPT_FRAME_COUNT,
    parameter int OFFSET_BITS = tlbpt_pkg::TLBPT_OFFSET_BITS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [tlbpt_pkg::TLBPT_VA_W-1:0]   virtual_address,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic      [tlbpt_pkg::TLBPT_PA_W-1:0]   physical_address,
    output logic      [1:0]                         outcome,
    output logic      [tlbpt_pkg::TLBPT_IDX_W-1:0]  frame_index,
    output logic      [tlbpt_pkg::TLBPT_IDX_W-1:0]  fault_page,
    output logic      [tlbpt_pkg::TLBPT_COUNT_W-1:0] tlb_hit_count,
    output logic      [tlbpt_pkg::TLBPT_COUNT_W-1:0] fault_count,
    output logic      [tlbpt_pkg::TLBPT_COUNT_W-1:0] address_count
);
    import tlbpt_pkg::*;

    localparam int PAGE_W   = $clog2(PAGE_COUNT);
    localparam int FRAME_W  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int ENTRY_W  = FRAME_W + 1;
    localparam int RAW_W    = (TLBPT_VA_W > OFFSET_BITS) ? TLBPT_VA_W - OFFSET_BITS : 1;
    localparam int PAGE_LOG = $clog2(PAGE_COUNT + 1) - 1;
    // conditional subtract steps for the page modulo
    localparam int MOD_STEPS = (RAW_W >= PAGE_LOG) ? RAW_W - PAGE_LOG + 1 : 1;

    // page number modulo PAGE_COUNT by restoring subtraction of shifted multiples
    function automatic logic [PAGE_W-1:0] page_of(input logic [TLBPT_VA_W-1:0] va);
        logic [TLBPT_VA_W-1:0] raw;
        logic [RAW_W-1:0]      rem;
        raw = va >> OFFSET_BITS;
        rem = raw[RAW_W-1:0];
        for (int k = MOD_STEPS - 1; k >= 0; k--)
        begin
            if (32'(rem) >= (32'(PAGE_COUNT) << k))
            begin
                rem = rem - RAW_W'(32'(PAGE_COUNT) << k);
            end
        end
        return PAGE_W'(rem);
    endfunction

    function automatic logic [TLBPT_COUNT_W-1:0] sat_inc(input logic [TLBPT_COUNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // control state
    tlbpt_state_t        state_reg;
    tlbpt_state_t        state_next;
    logic [PAGE_W-1:0]   clr_idx_reg;
    logic [FRAME_W-1:0]  free_frame_reg;
    logic                exhausted_reg;
    logic                out_valid_reg;
    logic [TLBPT_COUNT_W-1:0] hit_cnt_reg;
    logic [TLBPT_COUNT_W-1:0] fault_cnt_reg;
    logic [TLBPT_COUNT_W-1:0] addr_cnt_reg;

    // word being looked up
    logic [PAGE_W-1:0]      page_reg;
    logic [OFFSET_BITS-1:0] offset_reg;

    // output payload
    logic [TLBPT_PA_W-1:0]  phys_reg;
    tlbpt_outcome_t         outcome_reg;
    logic [TLBPT_IDX_W-1:0] frame_out_reg;
    logic [TLBPT_IDX_W-1:0] fault_page_reg;

    // memory and tlb hookup
    tlbpt_mem_ctl_t      mem_ctl;
    logic [PAGE_W-1:0]   mem_rd_addr;
    logic [PAGE_W-1:0]   mem_wr_addr;
    logic [ENTRY_W-1:0]  mem_wr_data;
    logic [ENTRY_W-1:0]  mem_rd_data;
    logic                tlb_hit;
    logic [FRAME_W-1:0]  tlb_frame;
    logic                tlb_ins_en;

    // lookup decision
    logic                can_emit;
    logic                commit;
    logic                pt_valid;
    logic [FRAME_W-1:0]  pt_frame;
    tlbpt_outcome_t      dec_outcome;
    logic [FRAME_W-1:0]  dec_frame;
    logic [31:0]         frame_ext;
    logic [31:0]         phys_wide;
    logic [31:0]         page_ext;
    logic                clr_last;

    assign pt_valid = mem_rd_data[ENTRY_W-1];
    assign pt_frame = mem_rd_data[FRAME_W-1:0];
    assign clr_last = (clr_idx_reg == PAGE_W'(PAGE_COUNT - 1));

    // the output register is free when empty or being taken this cycle
    assign can_emit = !out_valid_reg || out_ready;
    assign commit   = (state_reg == ST_LOOKUP) && can_emit;

    tlbpt_ptmem #(
        .DEPTH  (PAGE_COUNT),
        .ADDR_W (PAGE_W),
        .DATA_W (ENTRY_W)
    ) u_ptmem (
        .clk     (clk),
        .ctl     (mem_ctl),
        .rd_addr (mem_rd_addr),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    tlbpt_tlb #(
        .TLB_SLOTS (TLB_SLOTS),
        .PAGE_W    (PAGE_W),
        .FRAME_W   (FRAME_W)
    ) u_tlb (
        .clk         (clk),
        .rst_n       (rst_n),
        .lookup_page (page_reg),
        .hit         (tlb_hit),
        .hit_frame   (tlb_frame),
        .ins_en      (tlb_ins_en),
        .ins_page    (page_reg),
        .ins_frame   (dec_frame)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (can_emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // tlb first, then page table, then allocate a fresh frame
    always_comb
    begin
        if (tlb_hit)
        begin
            dec_outcome = OUT_TLB_HIT;
            dec_frame   = tlb_frame;
        end
        else if (pt_valid)
        begin
            dec_outcome = OUT_PT_HIT;
            dec_frame   = pt_frame;
        end
        else if (!exhausted_reg)
        begin
            dec_outcome = OUT_FAULT_ALLOC;
            dec_frame   = free_frame_reg;
        end
        else
        begin
            dec_outcome = OUT_FAULT_NONE;
            dec_frame   = '0;
        end
        frame_ext = 32'(dec_frame);
        page_ext  = 32'(page_reg);
        phys_wide = (frame_ext << OFFSET_BITS) | 32'(offset_reg);
    end

    // outputs per state
    always_comb
    begin
        in_ready    = 1'b0;
        mem_ctl     = '0;
        mem_rd_addr = page_of(virtual_address);
        mem_wr_addr = clr_idx_reg;
        mem_wr_data = '0;
        tlb_ins_en  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_ctl.wr_en = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                mem_ctl.rd_en = in_valid;
            end
            ST_LOOKUP:
            begin
                mem_wr_addr   = page_reg;
                mem_wr_data   = {1'b1, dec_frame};
                mem_ctl.wr_en = commit && (dec_outcome == OUT_FAULT_ALLOC);
                tlb_ins_en    = commit && ((dec_outcome == OUT_PT_HIT) ||
                                           (dec_outcome == OUT_FAULT_ALLOC));
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_idx_reg    <= '0;
            free_frame_reg <= '0;
            exhausted_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            hit_cnt_reg    <= '0;
            fault_cnt_reg  <= '0;
            addr_cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
                addr_cnt_reg  <= sat_inc(addr_cnt_reg);
                if (dec_outcome == OUT_TLB_HIT)
                begin
                    hit_cnt_reg <= sat_inc(hit_cnt_reg);
                end
                if ((dec_outcome == OUT_FAULT_ALLOC) || (dec_outcome == OUT_FAULT_NONE))
                begin
                    fault_cnt_reg <= sat_inc(fault_cnt_reg);
                end
                if (dec_outcome == OUT_FAULT_ALLOC)
                begin
                    if (free_frame_reg == FRAME_W'(FRAME_COUNT - 1))
                    begin
                        exhausted_reg <= 1'b1;
                    end
                    else
                    begin
                        free_frame_reg <= free_frame_reg + 1'b1;
                    end
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            page_reg   <= page_of(virtual_address);
            offset_reg <= virtual_address[OFFSET_BITS-1:0];
        end
        if (commit)
        begin
            outcome_reg    <= dec_outcome;
            frame_out_reg  <= frame_ext[TLBPT_IDX_W-1:0];
            phys_reg       <= (dec_outcome == OUT_FAULT_NONE) ? '0 : phys_wide[TLBPT_PA_W-1:0];
            fault_page_reg <= ((dec_outcome == OUT_FAULT_ALLOC) ||
                               (dec_outcome == OUT_FAULT_NONE)) ?
                              page_ext[TLBPT_IDX_W-1:0] : '0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign physical_address = phys_reg;
    assign outcome          = outcome_reg;
    assign frame_index      = frame_out_reg;
    assign fault_page       = fault_page_reg;
    // counters only move when a new word enters the output register
    assign tlb_hit_count    = hit_cnt_reg;
    assign fault_count      = fault_cnt_reg;
    assign address_count    = addr_cnt_reg;

endmodule

`default_nettype wire

// File: rtl/tlbpt_checker.sv
// port-level checks for the translator, bound to the top level
`default_nettype none

`include "tlb_page_table_translator_defines.svh"

module tlbpt_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               in_valid,
    input wire logic                               in_ready,
    input wire logic [tlbpt_pkg::TLBPT_VA_W-1:0]   virtual_address,
    input wire logic                               out_valid,
    input wire logic                               out_ready,
    input wire logic [tlbpt_pkg::TLBPT_PA_W-1:0]   physical_address,
    input wire logic [1:0]                         outcome,
    input wire logic [tlbpt_pkg::TLBPT_IDX_W-1:0]  frame_index,
    input wire logic [tlbpt_pkg::TLBPT_IDX_W-1:0]  fault_page,
    input wire logic [tlbpt_pkg::TLBPT_COUNT_W-1:0] tlb_hit_count,
    input wire logic [tlbpt_pkg::TLBPT_COUNT_W-1:0] fault_count,
    input wire logic [tlbpt_pkg::TLBPT_COUNT_W-1:0] address_count
);
    import tlbpt_pkg::*;

    logic unused_inputs;
    assign unused_inputs = in_valid ^ in_ready ^ (^virtual_address);

    // a stalled result word keeps its counter snapshot
    `TLBPT_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(address_count))

    // no free frame gives a zero address and frame
    `TLBPT_ASSERT_NOW(a_no_frame_zero, clk, rst_n, out_valid && (outcome == OUT_FAULT_NONE), (physical_address == '0) && (frame_index == '0))

    // hits never report a fault page
    `TLBPT_ASSERT_NOW(a_hit_no_fault_page, clk, rst_n, out_valid && ((outcome == OUT_TLB_HIT) || (outcome == OUT_PT_HIT)), fault_page == '0)

    // hit and fault counts never pass the address count
    `TLBPT_ASSERT_NOW(a_counts_bounded, clk, rst_n, out_valid, (tlb_hit_count <= address_count) && (fault_count <= address_count))

endmodule

bind tlb_page_table_translator tlbpt_checker u_tlbpt_checker (.*);

`default_nettype wire
